@@ rtl/tcbe_pkg.sv @@
// ----------------------------------------------------------------------------
// tcbe_pkg
// Shared request codes, datapath operation codes and the command and status
// structures that join the text cell buffer controller and datapath.
// ----------------------------------------------------------------------------
package tcbe_pkg;

  // Request type codes carried by an input item.
  localparam logic [2:0] REQ_PLOT      = 3'd0;
  localparam logic [2:0] REQ_ATTR      = 3'd1;
  localparam logic [2:0] REQ_CLEAR     = 3'd2;
  localparam logic [2:0] REQ_SCROLL    = 3'd3;
  localparam logic [2:0] REQ_CLR_DIRTY = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // Character written into every cleared or exposed cell.
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_INIT     = 4'd1;
  localparam logic [3:0] OP_PLOT     = 4'd2;
  localparam logic [3:0] OP_ATTR_RD  = 4'd3;
  localparam logic [3:0] OP_ATTR_WR  = 4'd4;
  localparam logic [3:0] OP_HSTEP    = 4'd5;
  localparam logic [3:0] OP_RUN_WR   = 4'd6;
  localparam logic [3:0] OP_MARK_RUN = 4'd7;
  localparam logic [3:0] OP_CP_RD    = 4'd8;
  localparam logic [3:0] OP_CP_WR    = 4'd9;
  localparam logic [3:0] OP_BL_WR    = 4'd10;
  localparam logic [3:0] OP_MARK_SCR = 4'd11;
  localparam logic [3:0] OP_CLR_RECT = 4'd12;
  localparam logic [3:0] OP_OUT      = 4'd13;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
  } tcbe_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       in_bounds;
    logic       run_nz;
    logic       scroll_ok;
    logic       lines_zero;
    logic       h_done;
    logic       run_last;
    logic       col_last;
    logic       rows_last;
    logic       out_free;
  } tcbe_stat_t;

endpackage

@@ rtl/tcbe_dp.sv @@
// ----------------------------------------------------------------------------
// tcbe_dp
// Datapath: request registers, the cell store, loop counters for clears and
// scrolls, the dirty rectangle and the result register.
// ----------------------------------------------------------------------------
module tcbe_dp #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcbe_pkg::tcbe_cmd_t             cmd,
  output tcbe_pkg::tcbe_stat_t            stat,
  input  logic [$clog2(MAX_COLS+1)-1:0]   nc,
  input  logic [$clog2(MAX_ROWS+1)-1:0]   nr,
  input  logic [2:0]                      in_req_type,
  input  logic [6:0]                      in_col,
  input  logic [5:0]                      in_row,
  input  logic [7:0]                      in_value,
  input  logic [7:0]                      in_cur_attr,
  input  logic [13:0]                     in_run_length,
  input  logic [5:0]                      in_top_row,
  input  logic [5:0]                      in_bottom_row,
  input  logic signed [6:0]               in_shift_lines,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_old_attr,
  output logic                            out_dirty_valid,
  output logic [6:0]                      out_dirty_x,
  output logic [5:0]                      out_dirty_y,
  output logic [7:0]                      out_dirty_w,
  output logic [6:0]                      out_dirty_h
);
  import tcbe_pkg::*;

  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS+1);
  localparam int RW    = $clog2(MAX_ROWS+1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = CW + RW;

  // Captured request.
  logic [2:0]        type_r;
  logic [6:0]        req_col_r;
  logic [5:0]        req_row_r;
  logic [7:0]        val_r;
  logic [7:0]        attr_r;
  logic [13:0]       run_r;
  logic [5:0]        top_r;
  logic [5:0]        bot_r;
  logic signed [6:0] lines_r;

  // Loop state.
  logic [AW-1:0]  addr_r;
  logic [TW-1:0]  rem_r;
  logic [TW-1:0]  hacc_r;
  logic [RW-1:0]  hcnt_r;
  logic [CIW-1:0] col_r;
  logic [RIW-1:0] dst_row_r;
  logic [RIW-1:0] src_row_r;
  logic [RW-1:0]  rows_left_r;

  // Dirty rectangle.
  logic [CIW-1:0] rect_l_r;
  logic [RIW-1:0] rect_t_r;
  logic [CW-1:0]  rect_w_r;
  logic [RW-1:0]  rect_h_r;

  // Cell store and its read register.
  logic [15:0] store_r [DEPTH];
  logic [15:0] rd_data_r;

  logic [7:0] old_attr_r;
  logic       out_valid_r;
  logic [7:0] out_old_r;
  logic       out_dv_r;
  logic [6:0] out_x_r;
  logic [5:0] out_y_r;
  logic [7:0] out_w_r;
  logic [6:0] out_h_r;

  logic [TW-1:0]  idx_c;
  logic [TW-1:0]  total_c;
  logic [TW-1:0]  room_c;
  logic [TW-1:0]  rem_init_c;
  logic           inside_c;
  logic           scroll_ok_c;
  logic           dir_down_c;
  logic [RIW-1:0] dst_init_c;
  logic [RIW-1:0] src_init_c;
  logic [RIW-1:0] blank_row_c;
  logic [RW-1:0]  copy_rows_c;
  logic [RW-1:0]  mag_c;
  logic [RW-1:0]  span_c;
  logic [TW-1:0]  dst_addr_c;
  logic [TW-1:0]  src_addr_c;
  logic           col_last_c;
  logic           we_c;
  logic [AW-1:0]  waddr_c;
  logic [15:0]    wdata_c;
  logic           re_c;
  logic [AW-1:0]  raddr_c;
  logic           mark_c;
  logic [CIW-1:0] nl_c;
  logic [RIW-1:0] nt_c;
  logic [CW-1:0]  nw_c;
  logic [RW-1:0]  nh_c;

  // Request decode and scroll geometry.
  always_comb begin
    int botv;
    int topv;
    int magv;
    idx_c      = TW'(req_row_r) * TW'(nc) + TW'(req_col_r);
    total_c    = TW'(nc) * TW'(nr);
    room_c     = total_c - idx_c;
    rem_init_c = (int'(run_r) > int'(room_c)) ? room_c : TW'(run_r);
    inside_c   = (int'(req_col_r) < int'(nc)) && (int'(req_row_r) < int'(nr));

    topv = int'(top_r);
    botv = (int'(bot_r) > int'(nr) - 1) ? int'(nr) - 1 : int'(bot_r);
    magv = (lines_r < 0) ? -int'(lines_r) : int'(lines_r);
    scroll_ok_c = (botv >= topv) && (magv < botv - topv);
    dir_down_c  = !lines_r[6];
    mag_c       = RW'(magv);
    copy_rows_c = RW'(botv - topv - magv + 1);
    span_c      = RW'(botv - topv + 1);
    if (dir_down_c) begin
      dst_init_c  = RIW'(botv);
      src_init_c  = RIW'(botv - magv);
      blank_row_c = RIW'(topv);
    end else begin
      dst_init_c  = RIW'(topv);
      src_init_c  = RIW'(topv + magv);
      blank_row_c = RIW'(botv + 1 - magv);
    end
  end

  assign dst_addr_c = TW'(dst_row_r) * TW'(nc) + TW'(col_r);
  assign src_addr_c = TW'(src_row_r) * TW'(nc) + TW'(col_r);
  assign col_last_c = int'(col_r) == int'(nc) - 1;

  // Store write and read port selection.
  always_comb begin
    we_c    = 1'b0;
    waddr_c = AW'(idx_c);
    wdata_c = {attr_r, val_r};
    re_c    = 1'b0;
    raddr_c = AW'(idx_c);
    unique case (cmd.op)
      OP_PLOT: begin
        we_c = 1'b1;
      end
      OP_ATTR_RD: begin
        re_c = 1'b1;
      end
      OP_ATTR_WR: begin
        we_c    = 1'b1;
        wdata_c = {val_r, rd_data_r[7:0]};
      end
      OP_RUN_WR: begin
        we_c    = 1'b1;
        waddr_c = addr_r;
        wdata_c = {attr_r, BLANK_CHAR};
      end
      OP_CP_RD: begin
        re_c    = 1'b1;
        raddr_c = AW'(src_addr_c);
      end
      OP_CP_WR: begin
        we_c    = 1'b1;
        waddr_c = AW'(dst_addr_c);
        wdata_c = rd_data_r;
      end
      OP_BL_WR: begin
        we_c    = 1'b1;
        waddr_c = AW'(dst_addr_c);
        wdata_c = {attr_r, BLANK_CHAR};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      store_r[waddr_c] <= wdata_c;
    end
    if (re_c) begin
      rd_data_r <= store_r[raddr_c];
    end
  end

  // Bounding-box union of the rectangle with the cells just touched.
  always_comb begin
    int x;
    int y;
    int w;
    int h;
    int l;
    int t;
    int r;
    int b;
    mark_c = 1'b0;
    x = int'(req_col_r);
    y = int'(req_row_r);
    w = 1;
    h = 1;
    unique case (cmd.op)
      OP_PLOT, OP_ATTR_WR: begin
        mark_c = 1'b1;
      end
      OP_MARK_RUN: begin
        mark_c = 1'b1;
        x = 0;
        w = int'(nc);
        h = int'(hcnt_r);
      end
      OP_MARK_SCR: begin
        mark_c = 1'b1;
        x = 0;
        y = int'(top_r);
        w = int'(nc);
        h = int'(span_c);
      end
      default: begin
      end
    endcase
    if (rect_w_r != '0) begin
      l = (x < int'(rect_l_r)) ? x : int'(rect_l_r);
      t = (y < int'(rect_t_r)) ? y : int'(rect_t_r);
      r = (x + w > int'(rect_l_r) + int'(rect_w_r)) ? x + w
                                                    : int'(rect_l_r) + int'(rect_w_r);
      b = (y + h > int'(rect_t_r) + int'(rect_h_r)) ? y + h
                                                    : int'(rect_t_r) + int'(rect_h_r);
    end else begin
      l = x;
      t = y;
      r = x + w;
      b = y + h;
    end
    nl_c = CIW'(l);
    nt_c = RIW'(t);
    nw_c = CW'(r - l);
    nh_c = RW'(b - t);
  end

  // Request capture and loop counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r     <= in_req_type;
      req_col_r  <= in_col;
      req_row_r  <= in_row;
      val_r      <= in_value;
      attr_r     <= in_cur_attr;
      run_r      <= in_run_length;
      top_r      <= in_top_row;
      bot_r      <= in_bottom_row;
      lines_r    <= in_shift_lines;
      old_attr_r <= 8'h00;
    end
    unique case (cmd.op)
      OP_INIT: begin
        addr_r      <= AW'(idx_c);
        rem_r       <= rem_init_c;
        hacc_r      <= '0;
        hcnt_r      <= '0;
        col_r       <= '0;
        dst_row_r   <= dst_init_c;
        src_row_r   <= src_init_c;
        rows_left_r <= copy_rows_c;
      end
      OP_ATTR_WR: begin
        old_attr_r <= rd_data_r[15:8];
      end
      OP_HSTEP: begin
        hacc_r <= hacc_r + TW'(nc);
        hcnt_r <= hcnt_r + RW'(1);
      end
      OP_RUN_WR: begin
        addr_r <= addr_r + AW'(1);
        rem_r  <= rem_r - TW'(1);
      end
      OP_CP_WR: begin
        if (col_last_c) begin
          col_r <= '0;
          if (rows_left_r == RW'(1)) begin
            dst_row_r   <= blank_row_c;
            rows_left_r <= mag_c;
          end else begin
            rows_left_r <= rows_left_r - RW'(1);
            dst_row_r   <= dir_down_c ? dst_row_r - RIW'(1) : dst_row_r + RIW'(1);
            src_row_r   <= dir_down_c ? src_row_r - RIW'(1) : src_row_r + RIW'(1);
          end
        end else begin
          col_r <= col_r + CIW'(1);
        end
      end
      OP_BL_WR: begin
        if (col_last_c) begin
          col_r       <= '0;
          dst_row_r   <= dst_row_r + RIW'(1);
          rows_left_r <= rows_left_r - RW'(1);
        end else begin
          col_r <= col_r + CIW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Dirty rectangle and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_l_r    <= '0;
      rect_t_r    <= '0;
      rect_w_r    <= '0;
      rect_h_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR_RECT) begin
        rect_l_r <= '0;
        rect_t_r <= '0;
        rect_w_r <= '0;
        rect_h_r <= '0;
      end else if (mark_c) begin
        rect_l_r <= nl_c;
        rect_t_r <= nt_c;
        rect_w_r <= nw_c;
        rect_h_r <= nh_c;
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_old_r <= old_attr_r;
      out_dv_r  <= rect_w_r != '0;
      if (rect_w_r != '0) begin
        out_x_r <= 7'(rect_l_r);
        out_y_r <= 6'(rect_t_r);
        out_w_r <= (int'(rect_w_r) > 255) ? 8'hFF : 8'(rect_w_r);
        out_h_r <= (int'(rect_h_r) > 127) ? 7'h7F : 7'(rect_h_r);
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_w_r <= '0;
        out_h_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_old_attr    = out_old_r;
  assign out_dirty_valid = out_dv_r;
  assign out_dirty_x     = out_x_r;
  assign out_dirty_y     = out_y_r;
  assign out_dirty_w     = out_w_r;
  assign out_dirty_h     = out_h_r;

  always_comb begin
    stat.req_type   = type_r;
    stat.in_bounds  = inside_c;
    stat.run_nz     = run_r != '0;
    stat.scroll_ok  = scroll_ok_c;
    stat.lines_zero = lines_r == '0;
    stat.h_done     = (int'(hacc_r) >= int'(run_r) + int'(req_col_r)) ||
                      (int'(hcnt_r) == int'(nr) - int'(req_row_r));
    stat.run_last   = rem_r == TW'(1);
    stat.col_last   = col_last_c;
    stat.rows_last  = rows_left_r == RW'(1);
    stat.out_free   = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  a_run_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_RUN_WR |-> int'(addr_r) < int'(total_c))
    else $error("clear run writes past the buffer end");

  a_rect_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    rect_w_r != '0 |-> int'(rect_l_r) + int'(rect_w_r) <= MAX_COLS)
    else $error("dirty rectangle extends past the widest row");

  a_result_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dv_r == (out_w_r != '0)))
    else $error("dirty flag disagrees with reported width");
`endif

endmodule

@@ rtl/tcbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcbe_ctrl
// Controller state machine: sequences one request at a time through the
// datapath and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module tcbe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcbe_pkg::tcbe_stat_t stat,
  output tcbe_pkg::tcbe_cmd_t  cmd
);
  import tcbe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_PLOT = 4'd2;
  localparam logic [3:0] S_ARD  = 4'd3;
  localparam logic [3:0] S_AWR  = 4'd4;
  localparam logic [3:0] S_HGT  = 4'd5;
  localparam logic [3:0] S_RUN  = 4'd6;
  localparam logic [3:0] S_MRUN = 4'd7;
  localparam logic [3:0] S_CRD  = 4'd8;
  localparam logic [3:0] S_CWR  = 4'd9;
  localparam logic [3:0] S_BL   = 4'd10;
  localparam logic [3:0] S_MSCR = 4'd11;
  localparam logic [3:0] S_CLR  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.req_type)
          REQ_PLOT: begin
            state_nxt = stat.in_bounds ? S_PLOT : S_FIN;
          end
          REQ_ATTR: begin
            state_nxt = stat.in_bounds ? S_ARD : S_FIN;
          end
          REQ_CLEAR: begin
            if (stat.in_bounds && stat.run_nz) begin
              cmd.op    = OP_INIT;
              state_nxt = S_HGT;
            end else begin
              state_nxt = S_FIN;
            end
          end
          REQ_SCROLL: begin
            if (!stat.scroll_ok) begin
              state_nxt = S_FIN;
            end else if (stat.lines_zero) begin
              state_nxt = S_MSCR;
            end else begin
              cmd.op    = OP_INIT;
              state_nxt = S_CRD;
            end
          end
          REQ_CLR_DIRTY: begin
            state_nxt = S_CLR;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_PLOT: begin
        cmd.op    = OP_PLOT;
        state_nxt = S_FIN;
      end
      S_ARD: begin
        cmd.op    = OP_ATTR_RD;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.op    = OP_ATTR_WR;
        state_nxt = S_FIN;
      end
      S_HGT: begin
        if (stat.h_done) begin
          state_nxt = S_RUN;
        end else begin
          cmd.op = OP_HSTEP;
        end
      end
      S_RUN: begin
        cmd.op = OP_RUN_WR;
        if (stat.run_last) begin
          state_nxt = S_MRUN;
        end
      end
      S_MRUN: begin
        cmd.op    = OP_MARK_RUN;
        state_nxt = S_FIN;
      end
      S_CRD: begin
        cmd.op    = OP_CP_RD;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.op    = OP_CP_WR;
        state_nxt = (stat.col_last && stat.rows_last) ? S_BL : S_CRD;
      end
      S_BL: begin
        cmd.op = OP_BL_WR;
        if (stat.col_last && stat.rows_last) begin
          state_nxt = S_MSCR;
        end
      end
      S_MSCR: begin
        cmd.op    = OP_MARK_SCR;
        state_nxt = S_FIN;
      end
      S_CLR: begin
        cmd.op    = OP_CLR_RECT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DEC)
    else $error("accepted item did not move to decode");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && !stat.out_free |=> state_r == S_FIN)
    else $error("result dropped while output register was full");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("input ready raised while an item is in flight");
`endif

endmodule

@@ rtl/text_cell_buffer_engine.sv @@
// ----------------------------------------------------------------------------
// text_cell_buffer_engine
// Sequence: each request is decoded, then a plot writes its cell, an attribute
//   change reads and rewrites it, a clear counts rows, blanks cells and marks
//   them, a scroll copies, blanks and marks rows; clear dirty empties the box.
// Throughput: one item at a time, the next accepted only after the result
//   is loaded; the single store port and the cell-by-cell loops set the rate.
// Reset: synchronous, active low; clears controller, dirty rectangle, result
//   valid and the configuration registers (80 columns, 25 rows). The cell
//   store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module text_cell_buffer_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  // Request channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [6:0]        in_col,
  input  logic [5:0]        in_row,
  input  logic [7:0]        in_value,
  input  logic [7:0]        in_cur_attr,
  input  logic [13:0]       in_run_length,
  input  logic [5:0]        in_top_row,
  input  logic [5:0]        in_bottom_row,
  input  logic signed [6:0] in_shift_lines,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_old_attr,
  output logic              out_dirty_valid,
  output logic [6:0]        out_dirty_x,
  output logic [5:0]        out_dirty_y,
  output logic [7:0]        out_dirty_w,
  output logic [6:0]        out_dirty_h
);
  import tcbe_pkg::*;

  localparam int CW = $clog2(MAX_COLS+1);
  localparam int RW = $clog2(MAX_ROWS+1);

  // The column register holds the raw written value, the row one its low seven
  // bits. The geometry the datapath sees lies between one and the store's size.
  logic [7:0] cols_cfg_r;
  logic [6:0] rows_cfg_r;
  logic [CW-1:0] nc;
  logic [RW-1:0] nr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= 8'd80;
      rows_cfg_r <= 7'd25;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COLUMNS) begin
        cols_cfg_r <= cfg_wdata;
      end else begin
        rows_cfg_r <= cfg_wdata[6:0];
      end
    end
  end

  always_comb begin
    if (cols_cfg_r == '0) begin
      nc = CW'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      nr = RW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_cfg_r);
    end
  end

  // The controller steps each item through decode, the store loops and the
  // result hand-off; the datapath holds the store and the request arithmetic.
  tcbe_cmd_t  cmd;
  tcbe_stat_t stat;

  tcbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcbe_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .nc              (nc),
    .nr              (nr),
    .in_req_type     (in_req_type),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_value        (in_value),
    .in_cur_attr     (in_cur_attr),
    .in_run_length   (in_run_length),
    .in_top_row      (in_top_row),
    .in_bottom_row   (in_bottom_row),
    .in_shift_lines  (in_shift_lines),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_old_attr    (out_old_attr),
    .out_dirty_valid (out_dirty_valid),
    .out_dirty_x     (out_dirty_x),
    .out_dirty_y     (out_dirty_y),
    .out_dirty_w     (out_dirty_w),
    .out_dirty_h     (out_dirty_h)
  );

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cell buffer engine. Requests stream in
// through a randomly paced driver. A scoreboard predicts the dirty rectangle
// and the old attribute of every request, and checks each result against it.
// The bench steps through several buffer geometries, including the smallest
// and largest ones.
// ----------------------------------------------------------------------------
module tb_top;
  import tcbe_pkg::*;

  localparam int NCOL  = 128;
  localparam int NROW  = 64;
  localparam int DEPTH = NCOL * NROW;

  typedef struct {
    logic [2:0]        req;
    logic [6:0]        col;
    logic [5:0]        row;
    logic [7:0]        value;
    logic [7:0]        attr;
    logic [13:0]       run;
    logic [5:0]        top;
    logic [5:0]        bot;
    logic signed [6:0] shift;
  } cell_req_t;

  typedef struct {
    logic [7:0] old_attr;
    logic       dvalid;
    logic [6:0] dx;
    logic [5:0] dy;
    logic [7:0] dw;
    logic [6:0] dh;
  } rect_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_COLUMNS;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic [6:0] in_col = '0;
  logic [5:0] in_row = '0;
  logic [7:0] in_value = '0;
  logic [7:0] in_cur_attr = '0;
  logic [13:0] in_run_length = '0;
  logic [5:0] in_top_row = '0;
  logic [5:0] in_bottom_row = '0;
  logic signed [6:0] in_shift_lines = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_old_attr;
  logic out_dirty_valid;
  logic [6:0] out_dirty_x;
  logic [5:0] out_dirty_y;
  logic [7:0] out_dirty_w;
  logic [6:0] out_dirty_h;

  always #1 clk = ~clk;

  text_cell_buffer_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_col(in_col), .in_row(in_row), .in_value(in_value),
    .in_cur_attr(in_cur_attr), .in_run_length(in_run_length),
    .in_top_row(in_top_row), .in_bottom_row(in_bottom_row),
    .in_shift_lines(in_shift_lines),
    .out_valid(out_valid), .out_ready(out_ready), .out_old_attr(out_old_attr),
    .out_dirty_valid(out_dirty_valid), .out_dirty_x(out_dirty_x),
    .out_dirty_y(out_dirty_y), .out_dirty_w(out_dirty_w),
    .out_dirty_h(out_dirty_h)
  );

  // Shadow of the screen. The written flags track which cells hold a defined
  // value, so that an attribute change never reads a cell that was never set.
  logic [15:0] shadow_cells [DEPTH];
  bit          cell_written [DEPTH];
  int unsigned rect_x, rect_y, rect_w, rect_h;
  int unsigned cols_cfg = 80;
  int unsigned rows_cfg = 25;

  cell_req_t    req_q [$];
  rect_report_t report_q [$];
  cell_req_t    cur_req;
  int unsigned  n_pushed = 0;
  int unsigned  n_accepted = 0;
  bit           hold_off = 1'b0;
  bit           burst = 1'b0;
  bit           failed = 1'b0;
  int           send_gap = 0;
  int           sink_stall = 0;

  function automatic int unsigned used_cols();
    return (cols_cfg < 1) ? 1 : (cols_cfg > NCOL) ? NCOL : cols_cfg;
  endfunction

  function automatic int unsigned used_rows();
    return (rows_cfg < 1) ? 1 : (rows_cfg > NROW) ? NROW : rows_cfg;
  endfunction

  // Grow the dirty rectangle to the bounding box of itself and the new area.
  function automatic void grow_rect(int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h);
    if (rect_w != 0) begin
      if (x < rect_x) begin
        rect_w += rect_x - x;
        rect_x = x;
      end
      if (y < rect_y) begin
        rect_h += rect_y - y;
        rect_y = y;
      end
      if (x + w > rect_x + rect_w) rect_w = x + w - rect_x;
      if (y + h > rect_y + rect_h) rect_h = y + h - rect_y;
    end else begin
      rect_x = x;
      rect_y = y;
      rect_w = w;
      rect_h = h;
    end
  endfunction

  function automatic void set_cell(int unsigned idx, logic [7:0] ch, logic [7:0] at);
    shadow_cells[idx] = {at, ch};
    cell_written[idx] = 1'b1;
  endfunction

  function automatic void move_row(int unsigned dst, int unsigned src, int unsigned nc);
    for (int unsigned i = 0; i < nc; i++) begin
      shadow_cells[dst * nc + i] = shadow_cells[src * nc + i];
      cell_written[dst * nc + i] = cell_written[src * nc + i];
    end
  endfunction

  // Apply one request to the shadow screen and return the result it yields.
  function automatic rect_report_t apply_request(cell_req_t r);
    rect_report_t rep;
    int unsigned nc, nr, idx, n, h, bot, mag, total;
    int lines;
    bit in_buf;
    nc = used_cols();
    nr = used_rows();
    in_buf = (r.col < nc) && (r.row < nr);
    idx = r.col + r.row * nc;
    rep.old_attr = '0;
    case (r.req)
      REQ_PLOT: begin
        if (in_buf) begin
          set_cell(idx, r.value, r.attr);
          grow_rect(r.col, r.row, 1, 1);
        end
      end
      REQ_ATTR: begin
        if (in_buf) begin
          rep.old_attr = shadow_cells[idx][15:8];
          set_cell(idx, shadow_cells[idx][7:0], r.value);
          grow_rect(r.col, r.row, 1, 1);
        end
      end
      REQ_CLEAR: begin
        if (in_buf && r.run != 0) begin
          total = nc * nr;
          n = (r.run > total - idx) ? total - idx : r.run;
          for (int unsigned i = 0; i < n; i++) set_cell(idx + i, BLANK_CHAR, r.attr);
          h = (r.run + r.col + nc - 1) / nc;
          if (h > nr - r.row) h = nr - r.row;
          grow_rect(0, r.row, nc, h);
        end
      end
      REQ_SCROLL: begin
        bot = (r.bot > nr - 1) ? nr - 1 : r.bot;
        lines = r.shift;
        mag = (lines < 0) ? -lines : lines;
        if (bot >= r.top && mag < bot - r.top) begin
          if (lines > 0) begin
            for (int rr = bot; rr >= int'(r.top + mag); rr--) move_row(rr, rr - mag, nc);
            for (int unsigned rr = r.top; rr < r.top + mag; rr++)
              for (int unsigned i = 0; i < nc; i++) set_cell(rr * nc + i, BLANK_CHAR, r.attr);
          end else if (lines < 0) begin
            for (int unsigned rr = r.top; rr + mag <= bot; rr++) move_row(rr, rr + mag, nc);
            for (int unsigned rr = bot + 1 - mag; rr <= bot; rr++)
              for (int unsigned i = 0; i < nc; i++) set_cell(rr * nc + i, BLANK_CHAR, r.attr);
          end
          grow_rect(0, r.top, nc, bot - r.top + 1);
        end
      end
      REQ_CLR_DIRTY: begin
        rect_x = 0;
        rect_y = 0;
        rect_w = 0;
        rect_h = 0;
      end
      default: ;
    endcase
    if (rect_w != 0) begin
      rep.dvalid = 1'b1;
      rep.dx = rect_x[6:0];
      rep.dy = rect_y[5:0];
      rep.dw = (rect_w > 255) ? 8'd255 : rect_w[7:0];
      rep.dh = (rect_h > 127) ? 7'd127 : rect_h[6:0];
    end else begin
      rep.dvalid = 1'b0;
      rep.dx = '0;
      rep.dy = '0;
      rep.dw = '0;
      rep.dh = '0;
    end
    return rep;
  endfunction

  // Driver. A new item is raised only when the channel is free after this edge,
  // so valid is never dropped and raised again in the same step.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        report_q.push_back(apply_request(cur_req));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!hold_off && req_q.size() != 0) begin
          cur_req = req_q.pop_front();
          in_req_type <= cur_req.req;
          in_col <= cur_req.col;
          in_row <= cur_req.row;
          in_value <= cur_req.value;
          in_cur_attr <= cur_req.attr;
          in_run_length <= cur_req.run;
          in_top_row <= cur_req.top;
          in_bottom_row <= cur_req.bot;
          in_shift_lines <= cur_req.shift;
          in_valid <= 1'b1;
          send_gap = burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result is checked against the oldest prediction,
  // then the sink draws how long it stalls before the next one.
  always @(posedge clk) begin
    rect_report_t exp_rep;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        failed = 1'b1;
      end else begin
        exp_rep = report_q.pop_front();
        if (out_old_attr !== exp_rep.old_attr) begin
          $display("%0t: old_attr expected %0d got %0d", $time, exp_rep.old_attr, out_old_attr);
          failed = 1'b1;
        end
        if (out_dirty_valid !== exp_rep.dvalid) begin
          $display("%0t: dirty_valid expected %0d got %0d", $time, exp_rep.dvalid,
                   out_dirty_valid);
          failed = 1'b1;
        end
        if (out_dirty_x !== exp_rep.dx) begin
          $display("%0t: dirty_x expected %0d got %0d", $time, exp_rep.dx, out_dirty_x);
          failed = 1'b1;
        end
        if (out_dirty_y !== exp_rep.dy) begin
          $display("%0t: dirty_y expected %0d got %0d", $time, exp_rep.dy, out_dirty_y);
          failed = 1'b1;
        end
        if (out_dirty_w !== exp_rep.dw) begin
          $display("%0t: dirty_w expected %0d got %0d", $time, exp_rep.dw, out_dirty_w);
          failed = 1'b1;
        end
        if (out_dirty_h !== exp_rep.dh) begin
          $display("%0t: dirty_h expected %0d got %0d", $time, exp_rep.dh, out_dirty_h);
          failed = 1'b1;
        end
      end
      sink_stall = burst ? 0 : $urandom_range(0, 3);
      out_ready <= (sink_stall == 0);
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= (sink_stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Queue one request. An attribute change on a cell that holds no defined
  // value is turned into a plot; to judge that, all earlier items must have
  // been accepted so the written flags are current.
  task automatic queue_req(cell_req_t r);
    if (r.req == REQ_ATTR) begin
      wait (n_accepted == n_pushed);
      if (r.col < used_cols() && r.row < used_rows() &&
          !cell_written[r.col + r.row * used_cols()])
        r.req = REQ_PLOT;
    end
    wait (req_q.size() < 2);
    req_q.push_back(r);
    n_pushed++;
    @(posedge clk);
  endtask

  task automatic send_directed(logic [2:0] req, int col, int row, int value,
                               int attr, int run, int top, int bot, int shift);
    cell_req_t r;
    r.req = req;
    r.col = 7'(col);
    r.row = 6'(row);
    r.value = 8'(value);
    r.attr = 8'(attr);
    r.run = 14'(run);
    r.top = 6'(top);
    r.bot = 6'(bot);
    r.shift = 7'(shift);
    queue_req(r);
  endtask

  // Random request: mostly in-range cells and well-formed scroll regions,
  // with some out-of-range and malformed ones mixed in.
  task automatic send_random();
    cell_req_t r;
    int unsigned nc, nr, pick, span, mag;
    nc = used_cols();
    nr = used_rows();
    pick = $urandom_range(0, 99);
    if (pick < 30) r.req = REQ_PLOT;
    else if (pick < 50) r.req = REQ_ATTR;
    else if (pick < 65) r.req = REQ_CLEAR;
    else if (pick < 85) r.req = REQ_SCROLL;
    else if (pick < 95) r.req = REQ_CLR_DIRTY;
    else r.req = 3'($urandom_range(5, 7));
    r.col = 7'(($urandom_range(0, 99) < 85) ? $urandom_range(0, nc - 1)
                                            : $urandom_range(0, 127));
    r.row = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, nr - 1)
                                            : $urandom_range(0, 63));
    r.value = 8'($urandom_range(0, 255));
    r.attr = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 5) r.run = '0;
    else if (pick < 10) r.run = 14'($urandom_range(0, 8192));
    else r.run = 14'($urandom_range(1, 2 * nc + 5));
    if ($urandom_range(0, 99) < 80) begin
      r.top = 6'($urandom_range(0, nr - 1));
      r.bot = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(nr - 1, 63)
                                             : $urandom_range(r.top, nr - 1));
      span = ((r.bot > nr - 1) ? nr - 1 : r.bot) - r.top;
      mag = (span >= 1) ? $urandom_range(0, span - 1) : $urandom_range(0, 63);
      r.shift = 7'($urandom_range(0, 1) ? -int'(mag) : int'(mag));
    end else begin
      r.top = 6'($urandom_range(0, 63));
      r.bot = 6'($urandom_range(0, 63));
      r.shift = 7'(int'($urandom_range(0, 126)) - 63);
    end
    queue_req(r);
  endtask

  // Wait until every queued item has been accepted and answered, then let the
  // block settle before the next register write.
  task automatic drain();
    wait (req_q.size() == 0 && n_accepted == n_pushed && report_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_geometry(int unsigned cols, int unsigned rows);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= 8'(cols);
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= 8'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    cols_cfg = cols;
    rows_cfg = rows;
  endtask

  initial begin
    int unsigned phase_cols [7] = '{80, 1, 128, 16, 128, 1, 40};
    int unsigned phase_rows [7] = '{25, 1, 64, 8, 1, 64, 12};
    int unsigned phase_items [7] = '{230, 120, 40, 220, 120, 120, 180};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening on the reset geometry of 80 by 25.
    send_directed(REQ_PLOT, 0, 0, 8'h41, 8'h07, 0, 0, 0, 0);
    send_directed(REQ_PLOT, 79, 24, 8'hFF, 8'hFF, 0, 0, 0, 0);
    send_directed(REQ_PLOT, 80, 0, 1, 2, 0, 0, 0, 0);
    send_directed(REQ_PLOT, 0, 25, 1, 2, 0, 0, 0, 0);
    send_directed(REQ_ATTR, 0, 0, 8'h5A, 0, 0, 0, 0, 0);
    send_directed(REQ_ATTR, 127, 63, 8'hFF, 0, 0, 0, 0, 0);
    send_directed(REQ_CLR_DIRTY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_directed(REQ_CLEAR, 3, 2, 0, 8'h1F, 0, 0, 0, 0);
    send_directed(REQ_CLEAR, 5, 3, 0, 8'h1F, 200, 0, 0, 0);
    send_directed(REQ_CLEAR, 70, 24, 0, 8'hE0, 8192, 0, 0, 0);
    send_directed(REQ_CLEAR, 0, 0, 0, 8'h11, 2000, 0, 0, 0);
    send_directed(REQ_ATTR, 79, 24, 8'h33, 0, 0, 0, 0, 0);
    send_directed(REQ_CLR_DIRTY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h22, 0, 2, 10, -3);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h44, 0, 5, 20, 4);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h00, 0, 0, 24, 0);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h00, 0, 10, 5, 1);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h00, 0, 3, 8, 5);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h66, 0, 0, 63, 63);
    send_directed(REQ_SCROLL, 0, 0, 0, 8'h77, 0, 1, 63, -22);
    send_directed(REQ_ATTR, 40, 12, 8'hA5, 0, 0, 0, 0, 0);
    send_directed(3'd7, 1, 1, 1, 1, 1, 1, 1, 1);
    send_directed(REQ_CLR_DIRTY, 0, 0, 0, 0, 0, 0, 0, 0);

    // Random phases over a range of geometries, both extremes included.
    for (int p = 0; p < 7; p++) begin
      if (p != 0) write_geometry(phase_cols[p], phase_rows[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        // Once, hold the sender until the block has answered everything. The
        // pending queue must be handed to the driver before the hold starts.
        if (p == 0 && i == 100) begin
          wait (req_q.size() == 0);
          hold_off = 1'b1;
          drain();
          hold_off = 1'b0;
        end
        send_random();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
